// ===== rtl/lzrc_pkg.sv =====
// Shared types and constants for the LZ run/copy decompressor core.
// Holds the controller-to-datapath command and status structs and the status codes.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package lzrc_pkg;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 7;
   localparam int SIZE_W   = 32;
   localparam int PROD_W   = 27;
   localparam int DIST_W   = 16;
   localparam int STATUS_W = 3;

   localparam logic [PROD_W-1:0] MAX_SIZE_RESET = 27'd67108864;

   localparam logic [STATUS_W-1:0] STS_RUNNING   = 3'd0;
   localparam logic [STATUS_W-1:0] STS_COMPLETE  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_BAD_SIZE  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_TRUNCATED = 3'd3;
   localparam logic [STATUS_W-1:0] STS_BAD_DIST  = 3'd4;
   localparam logic [STATUS_W-1:0] STS_OVERRUN   = 3'd5;

   // What the output register is loaded with.
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_LIT,
      KIND_PAIR
   } kind_type;

   typedef struct packed {
      logic                latch;
      logic                hdr_shift;
      logic                run_load;
      logic                dist_load;
      logic                lit_put;
      logic                copy_start;
      logic                copy_read;
      logic                copy_put;
      logic                out_load;
      kind_type            out_kind;
      logic [STATUS_W-1:0] out_status;
      logic                out_run_end;
   } cmd_type;

   typedef struct packed {
      logic in_last;
      logic hdr_last;
      logic size_bad;
      logic tok_lit;
      logic tok_cnt_zero;
      logic lit_over;
      logic run_one;
      logic run_zero;
      logic dist_bad;
      logic copy_over;
      logic at_size;
      logic at_size_inc;
      logic cnt_one;
   } stat_type;

endpackage

// ===== rtl/lzrc_datapath.sv =====
// Datapath of the LZ run/copy decompressor: input capture, header and run counters,
// history window memory, copy address generation and the result output register.
// Depends on lzrc_pkg; driven by commands from lzrc_ctrl.
module lzrc_datapath #(
   parameter int WINDOW_BYTES = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lzrc_pkg::cmd_type                    cmd,
   output lzrc_pkg::stat_type                   stat,
   input  logic [lzrc_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                 req_last_byte,
   input  logic                                 csr_write,
   input  logic [lzrc_pkg::PROD_W-1:0]          csr_max_size,
   output logic [lzrc_pkg::BYTE_W-1:0]          rsp_first_byte,
   output logic [lzrc_pkg::BYTE_W-1:0]          rsp_second_byte,
   output logic [1:0]                           rsp_byte_count,
   output logic [lzrc_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_run_end
);

   localparam int ADDR_W = $clog2(WINDOW_BYTES);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(WINDOW_BYTES - 1);
   localparam logic [16:0] WINDOW_EXT = 17'(WINDOW_BYTES);

   logic [lzrc_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          in_last_ff;
   logic [1:0]                    hdr_cnt_ff, hdr_cnt_in;
   logic [lzrc_pkg::SIZE_W-1:0]   decl_ff, decl_in;
   logic [lzrc_pkg::PROD_W-1:0]   produced_ff, produced_in;
   logic [lzrc_pkg::COUNT_W-1:0]  run_left_ff, run_left_in;
   logic [lzrc_pkg::BYTE_W-1:0]   dist_hi_ff;
   logic [lzrc_pkg::PROD_W-1:0]   max_size_ff;
   logic [ADDR_W-1:0]             wr_addr_ff, wr_addr_in;
   logic [ADDR_W-1:0]             rd_addr_ff, rd_addr_in;
   logic [1:0]                    cnt_ff, cnt_in;
   logic [lzrc_pkg::BYTE_W-1:0]   hold0_ff, hold1_ff;
   logic [lzrc_pkg::BYTE_W-1:0]   rd_data_ff;
   logic [lzrc_pkg::BYTE_W-1:0]   hist_mem [WINDOW_BYTES];

   logic [lzrc_pkg::BYTE_W-1:0]   first_ff, second_ff;
   logic [1:0]                    count_ff;
   logic [lzrc_pkg::STATUS_W-1:0] status_ff;
   logic                          run_end_ff;

   logic [lzrc_pkg::SIZE_W-1:0]   decl_shift;
   logic [lzrc_pkg::PROD_W-1:0]   produced_inc;
   logic [lzrc_pkg::DIST_W-1:0]   dist_val;
   logic [16:0]                   wr_ext;
   logic [16:0]                   dist_ext;
   logic [16:0]                   copy_base;
   logic [ADDR_W-1:0]             wr_addr_inc, rd_addr_inc;
   logic                          wr_en;
   logic [lzrc_pkg::BYTE_W-1:0]   wr_data;

   assign decl_shift   = {decl_ff[23:0], in_byte_ff};
   assign produced_inc = produced_ff + 27'd1;
   assign dist_val     = {dist_hi_ff, in_byte_ff};
   assign wr_ext       = 17'(wr_addr_ff);
   assign dist_ext     = {1'b0, dist_val};
   // Start of a copy: wr_addr - distance modulo the window; the distance is already
   // known to be no larger than the window.
   assign copy_base    = (wr_ext >= dist_ext) ? (wr_ext - dist_ext)
                                              : (wr_ext + WINDOW_EXT - dist_ext);
   assign wr_addr_inc  = (wr_addr_ff == ADDR_LAST) ? '0 : wr_addr_ff + 1'b1;
   assign rd_addr_inc  = (rd_addr_ff == ADDR_LAST) ? '0 : rd_addr_ff + 1'b1;
   assign wr_en        = cmd.lit_put | cmd.copy_put;
   assign wr_data      = cmd.copy_put ? rd_data_ff : in_byte_ff;

   always_comb begin
      hdr_cnt_in  = hdr_cnt_ff;
      decl_in     = decl_ff;
      produced_in = produced_ff;
      run_left_in = run_left_ff;
      wr_addr_in  = wr_addr_ff;
      rd_addr_in  = rd_addr_ff;
      cnt_in      = cnt_ff;
      if (cmd.hdr_shift) begin
         decl_in    = decl_shift;
         hdr_cnt_in = (hdr_cnt_ff == 2'd3) ? 2'd0 : hdr_cnt_ff + 2'd1;
      end
      if (cmd.run_load) begin
         run_left_in = in_byte_ff[6:0];
      end
      if (wr_en) begin
         produced_in = produced_inc;
         wr_addr_in  = wr_addr_inc;
         run_left_in = run_left_ff - 7'd1;
      end
      if (cmd.copy_start) begin
         rd_addr_in = copy_base[ADDR_W-1:0];
         cnt_in     = 2'd0;
      end
      if (cmd.copy_read) begin
         rd_addr_in = rd_addr_inc;
      end
      if (cmd.copy_put) begin
         cnt_in = cnt_ff + 2'd1;
      end
      if (cmd.out_load && (cmd.out_kind == lzrc_pkg::KIND_PAIR)) begin
         cnt_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff  <= '0;
         decl_ff     <= '0;
         produced_ff <= '0;
         run_left_ff <= '0;
         dist_hi_ff  <= '0;
         wr_addr_ff  <= '0;
         cnt_ff      <= '0;
         max_size_ff <= lzrc_pkg::MAX_SIZE_RESET;
      end else begin
         hdr_cnt_ff  <= hdr_cnt_in;
         decl_ff     <= decl_in;
         produced_ff <= produced_in;
         run_left_ff <= run_left_in;
         wr_addr_ff  <= wr_addr_in;
         cnt_ff      <= cnt_in;
         if (cmd.dist_load) begin
            dist_hi_ff <= in_byte_ff;
         end
         if (csr_write) begin
            max_size_ff <= csr_max_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      if (cmd.latch) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (cmd.copy_put) begin
         if (cnt_ff == 2'd0) begin
            hold0_ff <= rd_data_ff;
         end else begin
            hold1_ff <= rd_data_ff;
         end
      end
      if (cmd.out_load) begin
         status_ff  <= cmd.out_status;
         run_end_ff <= cmd.out_run_end;
         unique case (cmd.out_kind)
            lzrc_pkg::KIND_LIT: begin
               first_ff  <= in_byte_ff;
               second_ff <= '0;
               count_ff  <= 2'd1;
            end
            lzrc_pkg::KIND_PAIR: begin
               first_ff  <= hold0_ff;
               second_ff <= (cnt_ff == 2'd2) ? hold1_ff : '0;
               count_ff  <= cnt_ff;
            end
            default: begin
               first_ff  <= '0;
               second_ff <= '0;
               count_ff  <= 2'd0;
            end
         endcase
      end
   end

   // History window: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr_ff] <= wr_data;
      end
      if (cmd.copy_read) begin
         rd_data_ff <= hist_mem[rd_addr_ff];
      end
   end

   always_comb begin
      stat.in_last      = in_last_ff;
      stat.hdr_last     = (hdr_cnt_ff == 2'd3);
      stat.size_bad     = (decl_shift == '0) || (decl_shift > 32'(max_size_ff));
      stat.tok_lit      = in_byte_ff[7];
      stat.tok_cnt_zero = (in_byte_ff[6:0] == '0);
      stat.lit_over     = (32'(produced_ff) + 32'(in_byte_ff[6:0])) > decl_ff;
      stat.run_one      = (run_left_ff == 7'd1);
      stat.run_zero     = (run_left_ff == '0);
      stat.dist_bad     = (dist_val == '0) || (27'(dist_val) > produced_ff)
                          || (dist_ext > WINDOW_EXT);
      stat.copy_over    = (32'(produced_ff) + 32'(run_left_ff)) > decl_ff;
      stat.at_size      = (32'(produced_ff) == decl_ff);
      stat.at_size_inc  = (32'(produced_inc) == decl_ff);
      stat.cnt_one      = (cnt_ff == 2'd1);
   end

   assign rsp_first_byte  = first_ff;
   assign rsp_second_byte = second_ff;
   assign rsp_byte_count  = count_ff;
   assign rsp_status      = status_ff;
   assign rsp_run_end     = run_end_ff;

endmodule

// ===== rtl/lzrc_ctrl.sv =====
// Controller of the LZ run/copy decompressor: stream phase tracking, per-byte
// sequencing, copy loop control and the output valid flag.
// Depends on lzrc_pkg; commands lzrc_datapath and reads its status flags.
module lzrc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lzrc_pkg::stat_type  stat,
   output lzrc_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TOKEN,
      PH_LITERAL,
      PH_DIST_HI,
      PH_DIST_LO,
      PH_DONE
   } phase_type;

   state_type                     state_ff, state_in;
   phase_type                     phase_ff, phase_in;
   phase_type                     next_ph;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free;
   logic                          hit;
   logic [lzrc_pkg::STATUS_W-1:0] sts;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      next_ph  = phase_ff;
      hit      = 1'b0;
      sts      = lzrc_pkg::STS_RUNNING;
      unique case (state_ff)
         ST_IDLE: begin
            // Once a final status is out, beats are taken and dropped.
            if (req_valid && (phase_ff != PH_DONE)) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.out_load    = 1'b1;
               cmd.out_kind    = lzrc_pkg::KIND_NONE;
               cmd.out_run_end = 1'b1;
               state_in        = ST_IDLE;
               unique case (phase_ff)
                  PH_HEADER: begin
                     cmd.hdr_shift = 1'b1;
                     if (stat.hdr_last) begin
                        if (stat.size_bad) begin
                           sts = lzrc_pkg::STS_BAD_SIZE;
                        end else begin
                           next_ph = PH_TOKEN;
                        end
                     end
                  end
                  PH_TOKEN: begin
                     if (stat.tok_lit) begin
                        if (!stat.tok_cnt_zero && !stat.in_last) begin
                           if (stat.lit_over) begin
                              sts = lzrc_pkg::STS_OVERRUN;
                           end else begin
                              cmd.run_load = 1'b1;
                              next_ph      = PH_LITERAL;
                           end
                        end
                     end else begin
                        cmd.run_load = 1'b1;
                        next_ph      = PH_DIST_HI;
                     end
                     hit = stat.at_size;
                  end
                  PH_LITERAL: begin
                     cmd.lit_put  = 1'b1;
                     cmd.out_kind = lzrc_pkg::KIND_LIT;
                     if (stat.run_one) begin
                        next_ph = PH_TOKEN;
                     end
                     hit = stat.at_size_inc;
                  end
                  PH_DIST_HI: begin
                     cmd.dist_load = 1'b1;
                     next_ph       = PH_DIST_LO;
                  end
                  PH_DIST_LO: begin
                     if (stat.dist_bad) begin
                        sts = lzrc_pkg::STS_BAD_DIST;
                     end else if (stat.copy_over) begin
                        sts = lzrc_pkg::STS_OVERRUN;
                     end else if (stat.run_zero) begin
                        next_ph = PH_TOKEN;
                        hit     = stat.at_size;
                     end else begin
                        cmd.out_load    = 1'b0;
                        cmd.out_run_end = 1'b0;
                        cmd.copy_start  = 1'b1;
                        state_in        = ST_COPY_RD;
                     end
                  end
                  default: begin
                     cmd.out_load    = 1'b0;
                     cmd.out_run_end = 1'b0;
                  end
               endcase
               if (cmd.out_load) begin
                  if ((sts == lzrc_pkg::STS_RUNNING) && (next_ph == PH_TOKEN) && hit) begin
                     sts = lzrc_pkg::STS_COMPLETE;
                  end
                  if ((sts == lzrc_pkg::STS_RUNNING) && stat.in_last) begin
                     sts = lzrc_pkg::STS_TRUNCATED;
                  end
                  cmd.out_status = sts;
                  phase_in = (sts != lzrc_pkg::STS_RUNNING) ? PH_DONE : next_ph;
               end
            end
         end
         ST_COPY_RD: begin
            cmd.copy_read = 1'b1;
            state_in      = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.copy_put = 1'b1;
            state_in     = (stat.run_one || stat.cnt_one) ? ST_EMIT : ST_COPY_RD;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = lzrc_pkg::KIND_PAIR;
               if (stat.run_zero) begin
                  if (stat.at_size) begin
                     sts = lzrc_pkg::STS_COMPLETE;
                  end else if (stat.in_last) begin
                     sts = lzrc_pkg::STS_TRUNCATED;
                  end
                  cmd.out_status  = sts;
                  cmd.out_run_end = 1'b1;
                  phase_in = (sts != lzrc_pkg::STS_RUNNING) ? PH_DONE : PH_TOKEN;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_COPY_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_HEADER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A pending result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register loaded while a result still waits");

   // Every history write of a copy comes in the cycle right after its own read.
   a_read_before_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY_WR) |-> ($past(state_ff) == ST_COPY_RD))
      else $error("copy write without a preceding read");

   // The final status is sticky until reset.
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |=> (phase_ff == PH_DONE))
      else $error("stream left the finished phase");

endmodule

// ===== rtl/lz_run_copy_decompressor_core.sv =====
// A result is registered in the execute state after its input beat is accepted, once
// the output register is free; a copy's first result follows its last distance beat
// through the copy read, copy write and emit states. A beat is captured, then executed,
// before the next is taken; each copied byte passes a read and a write state.
// Reset (synchronous, active high) returns to the header phase with max_size at 64 MiB.
// The history window is not cleared: distances are checked against the bytes produced.
module lz_run_copy_decompressor_core #(
   parameter int WINDOW_BYTES = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Compressed input channel.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lzrc_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                 req_last_byte,
   // Decompressed result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lzrc_pkg::BYTE_W-1:0]          rsp_first_byte,
   output logic [lzrc_pkg::BYTE_W-1:0]          rsp_second_byte,
   output logic [1:0]                           rsp_byte_count,
   output logic [lzrc_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_run_end,
   // Capacity register write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lzrc_pkg::PROD_W-1:0]          csr_max_size
);

   // The controller walks each accepted beat through its phase: it captures the beat,
   // then in the execute state updates the header, run and distance state and loads
   // the output register. A copy token instead enters a read/write loop over the
   // history memory, packing up to two bytes per result beat. The output register lets the
   // next input beat be taken while a result still waits downstream.

   lzrc_pkg::cmd_type  cmd;
   lzrc_pkg::stat_type stat;
   logic               csr_write;

   // The capacity register is always writable; the user must write only while idle (not enforced).
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   lzrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lzrc_datapath #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .csr_write       (csr_write),
      .csr_max_size    (csr_max_size),
      .rsp_first_byte  (rsp_first_byte),
      .rsp_second_byte (rsp_second_byte),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_status      (rsp_status),
      .rsp_run_end     (rsp_run_end)
   );

endmodule

// ===== tb/lz_run_copy_decompressor_core_tb.sv =====
// Self-checking testbench for lz_run_copy_decompressor_core: one compressed stream per run.
// Holds its own decoder model, the stimulus tasks and the result checker.
// Depends on lzrc_pkg and rtl/lz_run_copy_decompressor_core.sv only.
module lz_run_copy_decompressor_core_tb;

   localparam int WINDOW      = 65536;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int GAP_PCT     = 9;

   // Where the decoder model stands between two input beats.
   typedef enum logic [2:0] {
      DP_HEADER,
      DP_TOKEN,
      DP_LITERAL,
      DP_DIST_HI,
      DP_DIST_LO,
      DP_DONE
   } dec_phase_type;

   // How this run's stream is brought to its end. The block keeps its final
   // status until reset, and reset is applied once, so each run picks one.
   typedef enum int {
      END_COMPLETE,
      END_TRUNC_MID,
      END_TRUNC_LIT_TOKEN,
      END_ZERO_DIST,
      END_FAR_DIST,
      END_LIT_OVERRUN,
      END_COPY_OVERRUN,
      END_BAD_SIZE
   } stream_end_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic [1:0] count;
      logic [2:0] status;
      logic       run_end;
   } out_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_first_byte;
   logic [7:0]  rsp_second_byte;
   logic [1:0]  rsp_byte_count;
   logic [2:0]  rsp_status;
   logic        rsp_run_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [26:0] csr_max_size = 27'd0;

   // Decoder model state, a private copy of what the block holds.
   dec_phase_type dph = DP_HEADER;
   logic [1:0]    hdr_cnt = 2'd0;
   logic [31:0]   decl = 32'd0;
   logic [26:0]   prod = 27'd0;
   logic [6:0]    run_left = 7'd0;
   logic [7:0]    dist_hi = 8'd0;
   logic [26:0]   cap = lzrc_pkg::MAX_SIZE_RESET;
   logic [7:0]    hist [WINDOW];

   // Bytes made by the beat being modeled, and result beats still owed by the block.
   logic [7:0]    made_bytes [$];
   out_word_type  due_words [$];

   int             errors = 0;
   int             items_sent = 0;
   bit             gaps_on = 1'b1;
   bit             tight = 1'b0;
   bit             finish_last = 1'b0;
   stream_end_type ending = END_COMPLETE;
   logic [31:0]    target_size = 32'd0;

   lz_run_copy_decompressor_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_first_byte  (rsp_first_byte),
      .rsp_second_byte (rsp_second_byte),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_status      (rsp_status),
      .rsp_run_end     (rsp_run_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_size    (csr_max_size)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // An output byte goes into the history window at the current output count.
   function automatic void record_byte(input logic [7:0] v);
      hist[16'(prod % WINDOW)] = v;
      prod = prod + 27'd1;
      made_bytes.push_back(v);
   endfunction

   // Advances the decoder model by one compressed byte and queues the result
   // beats it owes: one status-only beat when no bytes come out, otherwise the
   // bytes packed two to a beat, with the status and run_end on the last one.
   task automatic advance_decoder(input logic [7:0] b, input logic last);
      logic [2:0]   st;
      logic [6:0]   c;
      int unsigned  reach;
      int unsigned  nres;
      int unsigned  k;
      int unsigned  cnt;
      out_word_type w;
      if (dph == DP_DONE) return;
      made_bytes.delete();
      st = lzrc_pkg::STS_RUNNING;
      case (dph)
         DP_HEADER: begin
            decl = {decl[23:0], b};
            if (hdr_cnt == 2'd3) begin
               hdr_cnt = 2'd0;
               if (decl == 0 || decl > cap) st = lzrc_pkg::STS_BAD_SIZE;
               else dph = DP_TOKEN;
            end else begin
               hdr_cnt = hdr_cnt + 2'd1;
            end
         end
         DP_TOKEN: begin
            c = b[6:0];
            if (b[7]) begin
               // An empty literal token, or one that is the last byte, changes nothing.
               if (c != 0 && !last) begin
                  if (prod + c > decl) begin
                     st = lzrc_pkg::STS_OVERRUN;
                  end else begin
                     run_left = c;
                     dph = DP_LITERAL;
                  end
               end
            end else begin
               run_left = c;
               dph = DP_DIST_HI;
            end
         end
         DP_LITERAL: begin
            record_byte(b);
            run_left = run_left - 7'd1;
            if (run_left == 0) dph = DP_TOKEN;
         end
         DP_DIST_HI: begin
            dist_hi = b;
            dph = DP_DIST_LO;
         end
         default: begin
            // The distance is judged before the size, and a zero-length copy
            // still has its distance judged.
            reach = 32'({dist_hi, b});
            if (reach == 0 || reach > prod || reach > WINDOW) begin
               st = lzrc_pkg::STS_BAD_DIST;
            end else if (prod + run_left > decl) begin
               st = lzrc_pkg::STS_OVERRUN;
            end else begin
               for (k = 0; k < run_left; k++)
                  record_byte(hist[16'((prod - reach) % WINDOW)]);
               run_left = 7'd0;
               dph = DP_TOKEN;
            end
         end
      endcase
      if (st == lzrc_pkg::STS_RUNNING && dph == DP_TOKEN && prod == decl)
         st = lzrc_pkg::STS_COMPLETE;
      if (st == lzrc_pkg::STS_RUNNING && last) st = lzrc_pkg::STS_TRUNCATED;
      if (st != lzrc_pkg::STS_RUNNING) dph = DP_DONE;

      nres = (made_bytes.size() == 0) ? 1 : (made_bytes.size() + 1) / 2;
      for (k = 0; k < nres; k++) begin
         if (made_bytes.size() > 2 * k) cnt = (made_bytes.size() - 2 * k >= 2) ? 2 : 1;
         else cnt = 0;
         w.first   = (cnt >= 1) ? made_bytes[2 * k] : 8'h00;
         w.second  = (cnt == 2) ? made_bytes[2 * k + 1] : 8'h00;
         w.count   = cnt[1:0];
         w.status  = (k + 1 == nres) ? st : lzrc_pkg::STS_RUNNING;
         w.run_end = (k + 1 == nres);
         due_words.push_back(w);
      end
   endtask

   // Offers one compressed byte and returns right after the edge that takes it.
   // Valid stays high on return so back-to-back beats need no second drive.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      advance_decoder(b, last);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_literal_run(input logic [6:0] n);
      int j;
      send_byte({1'b1, n}, 1'b0);
      for (j = 0; j < n; j++)
         send_byte(8'($urandom_range(255)), finish_last && j == n - 1 && prod + 1 == decl);
   endtask

   task automatic send_copy(input logic [6:0] n, input logic [15:0] reach, input logic last_lo);
      send_byte({1'b0, n}, 1'b0);
      send_byte(reach[15:8], 1'b0);
      send_byte(reach[7:0], last_lo);
   endtask

   // The capacity register is only touched with nothing in flight, plus a margin
   // that covers the copy latency.
   task automatic write_capacity(input logic [26:0] v);
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_valid    <= 1'b1;
      csr_max_size <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cap = v;
   endtask

   // Sets the capacity, sometimes leaving the reset value in place, and sends the
   // four-byte big-endian declared size that the chosen ending needs.
   task automatic test_header();
      int          pick;
      int          k;
      logic [26:0] limit;
      logic [31:0] size;
      pick = $urandom_range(3);
      if (ending == END_BAD_SIZE) begin
         limit = (pick == 1) ? 27'd0 : 27'($urandom_range(lzrc_pkg::MAX_SIZE_RESET, 0));
      end else if (tight) begin
         case (pick)
            1: limit = 27'(target_size);
            2: limit = 27'($urandom_range(lzrc_pkg::MAX_SIZE_RESET, target_size));
            default: limit = lzrc_pkg::MAX_SIZE_RESET;
         endcase
      end else begin
         limit = (pick >= 2) ? 27'($urandom_range(lzrc_pkg::MAX_SIZE_RESET, 1 << 20))
                             : lzrc_pkg::MAX_SIZE_RESET;
      end
      if (pick == 0) limit = lzrc_pkg::MAX_SIZE_RESET;
      else write_capacity(limit);

      if (ending == END_BAD_SIZE) begin
         case ($urandom_range(2))
            0: size = 32'd0;
            1: size = 32'(limit) + 32'd1;
            default: size = 32'hFFFF_FFFF;
         endcase
      end else begin
         size = tight ? target_size : 32'(limit);
      end
      for (k = 3; k >= 0; k--) send_byte(size[8 * k +: 8], 1'b0);
   endtask

   // Empty runs, byte extremes, the one-byte copy, a fully overlapped copy of the
   // longest count (64 result beats) and a copy reaching back to the first byte.
   task automatic test_token_corners();
      send_byte(8'h80, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_copy(7'd0, 16'd1, 1'b0);
      send_copy(7'd1, 16'd1, 1'b0);
      send_copy(7'd127, 16'd2, 1'b0);
      send_copy(7'd3, prod[15:0], 1'b0);
   endtask

   // Capacity is only judged at the header, so later writes must not disturb the stream.
   task automatic test_capacity_rewrites();
      write_capacity(27'd0);
      write_capacity(lzrc_pkg::MAX_SIZE_RESET);
      write_capacity(27'($urandom_range(lzrc_pkg::MAX_SIZE_RESET, 0)));
   endtask

   // Well-formed literal runs and copies with random content. A tight stream is
   // filled up to its declared size, or to just short of it when an overrun
   // ending follows; otherwise the run stops on the beat count.
   task automatic test_random_runs();
      int          iter;
      int          room;
      int          keep;
      int          n;
      int          kind;
      int          far;
      logic [15:0] reach;
      iter = 0;
      keep = (ending == END_COMPLETE) ? 0 : 1;
      forever begin
         room = decl - prod;
         if (tight ? room <= ((ending == END_COMPLETE) ? 0 : 126) : items_sent >= 440) break;
         gaps_on = !(iter >= 25 && iter < 60);
         n = ($urandom_range(7) == 0) ? 127 : $urandom_range(40, 1);
         if (tight && n > room - keep) n = room - keep;
         far = (prod > 65535) ? 65535 : prod;
         reach = 16'($urandom_range(1) ? $urandom_range((far < 8) ? far : 8, 1)
                                       : $urandom_range(far, 1));
         kind = $urandom_range(19);
         if (kind < 8) begin
            send_literal_run(7'(n));
         end else if (kind < 17) begin
            send_copy(7'(n), reach, finish_last && n == room);
         end else if (kind == 17) begin
            send_byte(8'h80, 1'b0);
         end else if (kind == 18) begin
            send_copy(7'd0, reach, 1'b0);
         end else begin
            send_copy(7'(n), 16'(far), finish_last && n == room);
         end
         iter++;
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_stream_end();
      int          room;
      logic [6:0]  n;
      logic [15:0] reach;
      room = decl - prod;
      case (ending)
         END_TRUNC_MID: begin
            // Input runs out in the middle of a literal run or a copy token, or on an empty literal token.
            case ($urandom_range(3))
               0: begin
                  send_byte(8'h85, 1'b0);
                  send_byte(8'($urandom_range(255)), 1'b1);
               end
               1: send_byte(8'h04, 1'b1);
               2: begin
                  send_byte(8'h04, 1'b0);
                  send_byte(8'h00, 1'b1);
               end
               default: send_byte(8'h80, 1'b1);
            endcase
         end
         END_TRUNC_LIT_TOKEN: begin
            n = 7'($urandom_range(127, 1));
            send_byte({1'b1, n}, 1'b1);
         end
         END_ZERO_DIST: begin
            send_copy(7'($urandom_range(127, 0)), 16'd0, 1'($urandom_range(1)));
         end
         END_FAR_DIST: begin
            reach = $urandom_range(1) ? 16'hFFFF : 16'(prod + 1 + $urandom_range(50));
            send_copy(7'($urandom_range(127, 0)), reach, 1'b0);
         end
         END_LIT_OVERRUN: begin
            n = 7'($urandom_range(127, room + 1));
            send_byte({1'b1, n}, 1'b0);
         end
         END_COPY_OVERRUN: begin
            send_copy(7'($urandom_range(127, room + 1)), 16'($urandom_range(prod, 1)), 1'b0);
         end
         default: ;
      endcase
   endtask

   // Once a final status is out the block must swallow further beats silently.
   // Short streams are topped up here so every run offers a similar beat count.
   task automatic test_after_end();
      int j;
      j = 0;
      while (j < 2 || items_sent < 459) begin
         send_byte(8'($urandom_range(255)), 1'b0);
         j++;
      end
      send_byte(8'($urandom_range(255)), 1'b1);
   endtask

   // Result side: compare each accepted beat with the oldest owed one, then pick
   // the next cycle's ready. Both happen at the same edge, reading pre-edge values.
   always @(posedge clock) begin : rsp_side
      out_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            $error("unexpected result beat: byte_count %0d status %0d",
                   rsp_byte_count, rsp_status);
            errors++;
         end else begin
            want = due_words.pop_front();
            if (rsp_first_byte !== want.first) begin
               $error("first_byte: expected %0d, got %0d", want.first, rsp_first_byte);
               errors++;
            end
            if (rsp_second_byte !== want.second) begin
               $error("second_byte: expected %0d, got %0d", want.second, rsp_second_byte);
               errors++;
            end
            if (rsp_byte_count !== want.count) begin
               $error("byte_count: expected %0d, got %0d", want.count, rsp_byte_count);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end: expected %0d, got %0d", want.run_end, rsp_run_end);
               errors++;
            end
         end
      end
      rsp_ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
   end

   // A hung handshake anywhere ends the run here.
   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : main
      int pick;
      // Completion is the common ending; every other one gets an even share.
      pick = $urandom_range(10);
      ending = (pick > END_BAD_SIZE) ? END_COMPLETE : stream_end_type'(pick);
      tight = (ending == END_COMPLETE || ending == END_LIT_OVERRUN ||
               ending == END_COPY_OVERRUN);
      target_size = $urandom_range(1300, 900);
      finish_last = (ending == END_COMPLETE) && ($urandom_range(1) == 1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_header();
      if (ending != END_BAD_SIZE) begin
         test_token_corners();
         test_capacity_rewrites();
         test_random_runs();
      end else begin
         test_capacity_rewrites();
      end
      test_stream_end();
      test_after_end();

      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lzrc_pkg.sv
rtl/lzrc_datapath.sv
rtl/lzrc_ctrl.sv
rtl/lz_run_copy_decompressor_core.sv
tb/lz_run_copy_decompressor_core_tb.sv
